// File: rtl/sle_pkg.sv
// Shared types and codes for the sequential list engine.
package sle_pkg;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_PRIOR  = 3'd2,
        OP_NEXT   = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_POS     = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_NO_NEIGHBOR = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ROTATE,
        CMD_INSERT,
        CMD_DELETE
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } state_t;

endpackage

// File: rtl/sle_cell.sv
// One list slot: holds a word and takes a neighbor's word on rotate, insert or delete.
module sle_cell #(
    parameter int CW  = 8,
    parameter int IDX = 0
) (
    input  logic               clk,
    input  sle_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]      fill,
    input  logic [CW-1:0]      tgt,
    input  logic [31:0]        head_word,
    input  logic [31:0]        lower_word,
    input  logic [31:0]        upper_word,
    input  logic [31:0]        ins_word,
    output logic [31:0]        word
);
    import sle_pkg::*;

    localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
    localparam logic [CW:0] NEXT_W = (CW+1)'(IDX + 1);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [CW:0] fill_w;
    logic [CW:0] tgt_w;

    assign fill_w = {1'b0, fill};
    assign tgt_w  = {1'b0, tgt};

    always_comb
    begin
        word_next = word_reg;
        case (cmd)
            CMD_ROTATE:
            begin
                // last live slot wraps around to the head word
                if (NEXT_W == fill_w)
                    word_next = head_word;
                else if (NEXT_W < fill_w)
                    word_next = upper_word;
            end
            CMD_INSERT:
            begin
                if (IDX_W == tgt_w)
                    word_next = ins_word;
                else if (IDX_W > tgt_w && IDX_W <= fill_w)
                    word_next = lower_word;
            end
            CMD_DELETE:
            begin
                if (IDX_W >= tgt_w && NEXT_W < fill_w)
                    word_next = upper_word;
            end
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: rtl/sequential_list_engine.sv
// Top level of the sequential list engine: control, scan tracking and the chain of slot cells.
module sequential_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [7:0]  position,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic signed [31:0] out_value,
    output logic [7:0]  found_position,
    output logic [7:0]  list_count,
    output logic        is_empty
);
    // The list lives in a chain of CAPACITY cells. Get, locate, prior, next and
    // delete rotate the live words past the head cell once, one word a cycle,
    // before their result is loaded; insert, clear and the unused code skip the
    // rotation. Insert and delete shift the affected cells at once in the final
    // cycle. One request is in work at a time and the next one is taken in the
    // cycle after a result is loaded. The result sits in an output register, so a
    // new request is taken while the previous result waits to transfer; a finished
    // request holds until that register is free.
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW + 1 : 9;
    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [7:0]    pos_reg, pos_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] k_reg, k_next;
    logic          found_reg, found_next;
    logic          after_reg, after_next;
    logic [CW-1:0] midx_reg, midx_next;
    logic [31:0]   prev_reg, prev_next;
    logic [31:0]   sel_reg, sel_next;
    logic [31:0]   prior_reg, prior_next;
    logic [31:0]   nbr_reg, nbr_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   out_value_reg, out_value_next;
    logic [7:0]    fpos_reg, fpos_next;
    logic [7:0]    count_reg, count_next;
    logic          empty_reg, empty_next;

    logic          need_scan;
    logic          scan_step;
    logic          fire;
    cell_cmd_t     cell_cmd;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] fill_ext;
    logic [PW-1:0] pm1;
    logic [PW-1:0] k_ext;
    logic [PW-1:0] midx_p1;
    logic          ok_rd;
    logic          ok_ins;

    status_t       res_status;
    logic [31:0]   res_value;
    logic [7:0]    res_fpos;
    logic [PW-1:0] res_fill;
    logic          do_ins;
    logic          do_del;

    logic [31:0]   cell_word [CAPACITY];
    logic [31:0]   head;

    assign head     = cell_word[0];
    assign pos_ext  = PW'(pos_reg);
    assign fill_ext = PW'(fill_reg);
    assign pm1      = pos_ext - PW'(1);
    assign k_ext    = PW'(k_reg);
    assign midx_p1  = PW'(midx_reg) + PW'(1);
    assign ok_rd    = (pos_reg != 8'd0) && (pos_ext <= fill_ext);
    assign ok_ins   = (pos_reg != 8'd0) && (pos_ext <= fill_ext + PW'(1));

    always_comb
    begin
        case (op_reg)
            OP_GET, OP_LOCATE, OP_PRIOR, OP_NEXT, OP_DELETE: need_scan = 1'b1;
            default:                                         need_scan = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (!(need_scan && k_reg != fill_reg))
                    state_next = S_POST;
            S_POST:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        scan_step = 1'b0;
        fire      = 1'b0;
        unique case (state_reg)
            S_IDLE: in_stall = 1'b0;
            S_SCAN: scan_step = need_scan && (k_reg != fill_reg);
            S_POST: fire = !out_valid_reg || !out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    // result of the finished request
    always_comb
    begin
        res_status = ST_OK;
        res_value  = 32'd0;
        res_fpos   = 8'd0;
        res_fill   = fill_ext;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        case (op_reg)
            OP_GET:
                if (!ok_rd)
                    res_status = ST_BAD_POS;
                else
                    res_value = sel_reg;
            OP_LOCATE:
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else
                    res_fpos = midx_p1[7:0];
            OP_PRIOR:
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else if (midx_reg == '0)
                    res_status = ST_NO_NEIGHBOR;
                else
                    res_value = prior_reg;
            OP_NEXT:
                if (!found_reg)
                    res_status = ST_NOT_FOUND;
                else if (midx_p1 >= fill_ext)
                    res_status = ST_NO_NEIGHBOR;
                else
                    res_value = nbr_reg;
            OP_INSERT:
                if (!ok_ins)
                    res_status = ST_BAD_POS;
                else if (fill_ext >= CAP_W)
                    res_status = ST_FULL;
                else
                begin
                    do_ins   = 1'b1;
                    res_fill = fill_ext + PW'(1);
                end
            OP_DELETE:
                if (!ok_rd)
                    res_status = ST_BAD_POS;
                else
                begin
                    res_value = sel_reg;
                    do_del    = 1'b1;
                    res_fill  = fill_ext - PW'(1);
                end
            OP_CLEAR:
                res_fill = '0;
            default:
                res_status = ST_OK;
        endcase
    end

    always_comb
    begin
        if (scan_step)
            cell_cmd = CMD_ROTATE;
        else if (fire && do_ins)
            cell_cmd = CMD_INSERT;
        else if (fire && do_del)
            cell_cmd = CMD_DELETE;
        else
            cell_cmd = CMD_HOLD;
    end

    // request registers and scan trackers
    always_comb
    begin
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        found_next = found_reg;
        after_next = after_reg;
        midx_next  = midx_reg;
        prev_next  = prev_reg;
        sel_next   = sel_reg;
        prior_next = prior_reg;
        nbr_next   = nbr_reg;

        if (state_reg == S_IDLE && in_valid)
        begin
            op_next    = op_t'(op);
            pos_next   = position;
            val_next   = value;
            k_next     = '0;
            found_next = 1'b0;
            after_next = 1'b0;
        end

        if (scan_step)
        begin
            k_next    = k_reg + CW'(1);
            prev_next = head;
            if (k_ext == pm1)
                sel_next = head;
            // word right after the first match
            if (after_reg)
                nbr_next = head;
            if (!found_reg && head == val_reg)
            begin
                found_next = 1'b1;
                after_next = 1'b1;
                midx_next  = k_reg;
                prior_next = prev_reg;
            end
            else
                after_next = 1'b0;
        end

        if (fire)
            fill_next = res_fill[CW-1:0];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        fpos_next      = fpos_reg;
        count_next     = count_reg;
        empty_next     = empty_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            out_value_next = res_value;
            fpos_next      = res_fpos;
            count_next     = res_fill[7:0];
            empty_next     = (res_fill == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            after_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            after_reg     <= after_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        midx_reg      <= midx_next;
        prev_reg      <= prev_next;
        sel_reg       <= sel_next;
        prior_reg     <= prior_next;
        nbr_reg       <= nbr_next;
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        fpos_reg      <= fpos_next;
        count_reg     <= count_next;
        empty_reg     <= empty_next;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [31:0] lower_w;
            logic [31:0] upper_w;
            if (g == 0)
            begin : g_first
                assign lower_w = val_reg;
            end
            else
            begin : g_lower
                assign lower_w = cell_word[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign upper_w = '0;
            end
            else
            begin : g_upper
                assign upper_w = cell_word[g+1];
            end
            sle_cell #(
                .CW  (CW),
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cell_cmd),
                .fill       (fill_reg),
                .tgt        (pm1[CW-1:0]),
                .head_word  (head),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .ins_word   (val_reg),
                .word       (cell_word[g])
            );
        end
    endgenerate

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_value      = out_value_reg;
    assign found_position = fpos_reg;
    assign list_count     = count_reg;
    assign is_empty       = empty_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(fill_reg) <= CAP_W)
        else $error("fill count above capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> k_reg <= fill_reg)
        else $error("scan index past fill count");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("finished request did not reach output");

    a_fill_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fill_reg) |-> $past(fire))
        else $error("fill count changed outside completion");
`endif

endmodule
